// ===== rtl/core/afcrc_pkg.sv =====
// Shared types, constants and CRC-6 step functions for the addressed frame receiver.
package afcrc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned RemW  = 7;
  localparam int unsigned ChkW  = 6;

  localparam logic [RemW-1:0]  CrcPoly   = 7'h53;
  localparam logic [ByteW-1:0] IdReset   = 8'd1;

  typedef enum logic [1:0] {
    POS_ID    = 2'd0,
    POS_LEFT  = 2'd1,
    POS_RIGHT = 2'd2,
    POS_CHECK = 2'd3
  } frame_pos_e;

  typedef struct packed {
    logic               stop;
    logic               crc_ok;
    logic signed [ByteW-1:0] right_cmd;
    logic signed [ByteW-1:0] left_cmd;
  } result_t;

  // One bit of the CRC: reduce the remainder, then shift the new bit in.
  function automatic logic [RemW-1:0] crc_bit(input logic [RemW-1:0] rem, input logic b);
    logic [RemW-1:0] r;
    r = rem;
    if (r[RemW-1]) begin
      r = r ^ CrcPoly;
    end
    return {r[RemW-2:0], b};
  endfunction

  function automatic logic [RemW-1:0] crc_byte(input logic [RemW-1:0] rem,
                                               input logic [ByteW-1:0] b);
    logic [RemW-1:0] r;
    r = rem;
    for (int i = ByteW - 1; i >= 0; i--) begin
      r = crc_bit(r, b[i]);
    end
    return r;
  endfunction

  // Low six bits of the check byte followed by one zero bit.
  function automatic logic [RemW-1:0] crc_check(input logic [RemW-1:0] rem,
                                                input logic [ByteW-1:0] b);
    logic [RemW-1:0] r;
    r = rem;
    for (int i = ChkW - 1; i >= 0; i--) begin
      r = crc_bit(r, b[i]);
    end
    return crc_bit(r, 1'b0);
  endfunction

endpackage

// ===== rtl/core/afcrc_frame.sv =====
// Frame position sequencer, running CRC and held commands.
module afcrc_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic [afcrc_pkg::ByteW-1:0]  byte_i,
  input  logic [afcrc_pkg::ByteW-1:0]  station_id_i,
  output logic                         has_result_o,
  output afcrc_pkg::result_t           result_o
);

  afcrc_pkg::frame_pos_e pos_q, pos_d;
  logic [afcrc_pkg::RemW-1:0]   crc_q, crc_d;
  logic [afcrc_pkg::ByteW-1:0]  pend_left_q, pend_left_d;
  logic [afcrc_pkg::ByteW-1:0]  pend_right_q, pend_right_d;
  logic [afcrc_pkg::ByteW-1:0]  held_left_q, held_left_d;
  logic [afcrc_pkg::ByteW-1:0]  held_right_q, held_right_d;
  logic [afcrc_pkg::RemW-1:0]   chk_rem;
  logic                         ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= afcrc_pkg::POS_ID;
      crc_q        <= '0;
      pend_left_q  <= '0;
      pend_right_q <= '0;
      held_left_q  <= '0;
      held_right_q <= '0;
    end else if (en_i) begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      pend_left_q  <= pend_left_d;
      pend_right_q <= pend_right_d;
      held_left_q  <= held_left_d;
      held_right_q <= held_right_d;
    end
  end

  assign chk_rem = afcrc_pkg::crc_check(crc_q, byte_i);
  assign ok      = (chk_rem[afcrc_pkg::RemW-1:1] == '0);

  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    pend_left_d  = pend_left_q;
    pend_right_d = pend_right_q;
    held_left_d  = held_left_q;
    held_right_d = held_right_q;
    has_result_o = 1'b0;
    case (pos_q)
      afcrc_pkg::POS_ID: begin
        if (byte_i == station_id_i) begin
          crc_d = afcrc_pkg::crc_byte('0, byte_i);
          pos_d = afcrc_pkg::POS_LEFT;
        end
      end
      afcrc_pkg::POS_LEFT: begin
        pend_left_d = byte_i;
        crc_d       = afcrc_pkg::crc_byte(crc_q, byte_i);
        pos_d       = afcrc_pkg::POS_RIGHT;
      end
      afcrc_pkg::POS_RIGHT: begin
        pend_right_d = byte_i;
        crc_d        = afcrc_pkg::crc_byte(crc_q, byte_i);
        pos_d        = afcrc_pkg::POS_CHECK;
      end
      default: begin
        if (ok) begin
          held_left_d  = pend_left_q;
          held_right_d = pend_right_q;
        end
        crc_d        = '0;
        pos_d        = afcrc_pkg::POS_ID;
        has_result_o = 1'b1;
      end
    endcase
  end

  assign result_o.left_cmd  = held_left_d;
  assign result_o.right_cmd = held_right_d;
  assign result_o.crc_ok    = ok;
  assign result_o.stop      = (held_left_d == '0) && (held_right_d == '0);

endmodule

// ===== rtl/core/afcrc_out_reg.sv =====
// Output result register that holds a word until the sink takes it.
module afcrc_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  afcrc_pkg::result_t data_i,
  output logic               ready_o,
  output logic               valid_o,
  input  logic               take_i,
  output afcrc_pkg::result_t data_o
);

  logic               valid_q, valid_d;
  afcrc_pkg::result_t data_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/addressed_frame_crc6_receiver_unit.sv =====
// Top level of the addressed frame receiver with CRC-6 check.
//
//   channel   direction  payload                                 completes when
//   s_axis    in         tdata[7:0] rx_byte                      tvalid & tready
//   m_axis    out        tdata left/right, tuser crc_ok/stop     tvalid & tready
//   cfg       in         cfg_data_i station_id                   cfg_valid & cfg_ready
//
// One received byte is taken every cycle when the sink keeps up. A byte waits in the
// input register; the frame logic and CRC-6 update for that byte run between the
// input register and the result register, so a frame's result word is loaded into
// the result register as its check byte leaves the input register. A stalled result
// blocks the input register only when the byte waiting there would end a frame. Reset
// clears the frame state, the held commands and sets the station ID to one.
module addressed_frame_crc6_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Received bytes: [7:0] rx_byte.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // Results: tdata [7:0] left_cmd, [15:8] right_cmd.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,
  // Results: tuser [0] crc_ok, [1] stop.
  output logic [1:0]  m_axis_tuser_o,
  // Station ID register write.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [afcrc_pkg::ByteW-1:0] station_id_q;
  logic                        in_valid_q;
  logic [afcrc_pkg::ByteW-1:0] in_byte_q;
  logic                        has_result;
  logic                        out_ready;
  logic                        advance;
  afcrc_pkg::result_t          frame_result;
  afcrc_pkg::result_t          out_word;

  // Always writable; user's rule: software only writes it while idle, unchecked.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_id_q <= afcrc_pkg::IdReset;
    end else if (cfg_valid_i) begin
      station_id_q <= cfg_data_i;
    end
  end

  // The byte in the input register is consumed unless it ends a frame and the
  // result register is still full.
  assign advance         = in_valid_q && (!has_result || out_ready);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  afcrc_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .byte_i       (in_byte_q),
    .station_id_i (station_id_q),
    .has_result_o (has_result),
    .result_o     (frame_result)
  );

  afcrc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && has_result),
    .data_i  (frame_result),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid_o),
    .take_i  (m_axis_tready_i),
    .data_o  (out_word)
  );

  assign m_axis_tdata_o = {out_word.right_cmd, out_word.left_cmd};
  assign m_axis_tuser_o = {out_word.stop, out_word.crc_ok};

endmodule

// ===== rtl/core/afcrc_checker.sv =====
// Port-level checks for the addressed frame receiver, bound to the top level.
module afcrc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  logic [15:0] last_word_q;

  // Commands of the most recent delivered result; zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_word_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      last_word_q <= m_axis_tdata_o;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result valid dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result data changed while stalled");

  a_stop_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[1] == (m_axis_tdata_o == 16'd0)))
    else $error("stop flag does not match the held commands");

  a_failed_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o == last_word_q)
    else $error("failed frame changed the held commands");

endmodule

bind addressed_frame_crc6_receiver_unit afcrc_checker u_afcrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== dv/afcrc_frame_checker.sv =====
// Frame predictor and result word checker for the addressed CRC-6 frame receiver.
package afcrc_tb_pkg;

  localparam logic [6:0] Crc6Gen = 7'h53;

  // One CRC-6 step on the 7-bit working remainder: fold first, then shift in.
  function automatic logic [6:0] crc6_shift(input logic [6:0] rem, input logic din);
    logic [6:0] folded;
    folded = rem[6] ? (rem ^ Crc6Gen) : rem;
    return {folded[5:0], din};
  endfunction

  // Feeds the low count bits of data, most significant of them first.
  function automatic logic [6:0] crc6_feed(input logic [6:0] rem, input logic [7:0] data,
                                           input int count);
    logic [6:0] acc;
    acc = rem;
    for (int i = count - 1; i >= 0; i--) begin
      acc = crc6_shift(acc, data[i]);
    end
    return acc;
  endfunction

  // Finds the six check bits that close a frame with a zero remainder.
  function automatic logic [7:0] sealing_byte(input logic [7:0] id, input logic [7:0] left,
                                              input logic [7:0] right);
    logic [6:0] body;
    body = crc6_feed(crc6_feed(crc6_feed(7'd0, id, 8), left, 8), right, 8);
    for (int c = 0; c < 64; c++) begin
      if (crc6_feed(crc6_feed(body, 8'(c), 6), 8'h00, 1) == 7'd0) begin
        return 8'(c);
      end
    end
    return 8'h00;
  endfunction

endpackage

module afcrc_frame_checker
  import afcrc_pkg::*;
  import afcrc_tb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [15:0] res_data_i,
  input  logic [1:0]  res_user_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  output int unsigned mismatches_o,
  output int unsigned outstanding_o,
  output int unsigned bytes_o,
  output int unsigned words_o,
  output int unsigned passes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0]  StationIdAtReset = 8'd1;
  localparam int unsigned ReportLimit      = 10;

  logic [7:0]        station_id_q;
  frame_pos_e        frame_at;
  logic [6:0]        crc_run;
  logic signed [7:0] open_left;
  logic signed [7:0] open_right;
  logic signed [7:0] held_left;
  logic signed [7:0] held_right;
  result_t           awaited_words[$];

  task automatic report_word(input string why, input result_t want, input result_t got);
    mismatches_o++;
    if (mismatches_o <= ReportLimit) begin
      $display("%0t: %s: expected left %0d right %0d crc_ok %0b stop %0b, got left %0d right %0d crc_ok %0b stop %0b",
               $time, why, want.left_cmd, want.right_cmd, want.crc_ok, want.stop,
               got.left_cmd, got.right_cmd, got.crc_ok, got.stop);
    end
  endtask

  // Advances the frame state by one received byte and queues a word at each frame end.
  task automatic take_rx_byte(input logic [7:0] b);
    logic [6:0] rem;
    result_t    w;
    case (frame_at)
      POS_ID: begin
        if (b == station_id_q) begin
          crc_run  = crc6_feed(7'd0, b, 8);
          frame_at = POS_LEFT;
        end
      end
      POS_LEFT: begin
        open_left = b;
        crc_run   = crc6_feed(crc_run, b, 8);
        frame_at  = POS_RIGHT;
      end
      POS_RIGHT: begin
        open_right = b;
        crc_run    = crc6_feed(crc_run, b, 8);
        frame_at   = POS_CHECK;
      end
      default: begin
        // The top two bits of the check byte play no part.
        rem      = crc6_feed(crc6_feed(crc_run, b, 6), 8'h00, 1);
        w.crc_ok = (rem[6:1] == 6'd0);
        if (w.crc_ok) begin
          held_left  = open_left;
          held_right = open_right;
          passes_o++;
        end
        frame_at    = POS_ID;
        crc_run     = '0;
        w.left_cmd  = held_left;
        w.right_cmd = held_right;
        w.stop      = (held_left == 8'sd0) && (held_right == 8'sd0);
        awaited_words.push_back(w);
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      station_id_q  = StationIdAtReset;
      frame_at      = POS_ID;
      crc_run       = '0;
      open_left     = '0;
      open_right    = '0;
      held_left     = '0;
      held_right    = '0;
      awaited_words.delete();
      mismatches_o  = 0;
      outstanding_o = 0;
      bytes_o       = 0;
      words_o       = 0;
      passes_o      = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        station_id_q = cfg_data_i;
      end
      if (res_valid_i && res_ready_i) begin
        got.left_cmd  = res_data_i[7:0];
        got.right_cmd = res_data_i[15:8];
        got.crc_ok    = res_user_i[0];
        got.stop      = res_user_i[1];
        words_o++;
        if (awaited_words.size() == 0) begin
          report_word("result word with nothing due", '0, got);
        end else begin
          want = awaited_words.pop_front();
          if (got.left_cmd !== want.left_cmd || got.right_cmd !== want.right_cmd ||
              got.crc_ok !== want.crc_ok || got.stop !== want.stop) begin
            report_word("result word differs", want, got);
          end
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        bytes_o++;
        take_rx_byte(rx_data_i);
      end
      outstanding_o = awaited_words.size();
    end
  end

endmodule

// ===== dv/addressed_frame_crc6_receiver_unit_test.sv =====
// Stimulus, handshake pacing and verdict for the addressed CRC-6 frame receiver.
module addressed_frame_crc6_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import afcrc_tb_pkg::*;

  // A run counts as hung once this many cycles pass with no word moving on any channel.
  localparam int unsigned QuietLimit    = 4000;
  // Length of the one long receiver hold-off that backs the block up into its input.
  localparam int unsigned HoldOffCycles = 150;
  // Received bytes offered in each random phase.
  localparam int unsigned PhaseBytes    = 195;
  // Cycles allowed after the last result word for a byte still in the input register.
  localparam int unsigned SettleCycles  = 4;

  // Pacing of the four phases: free running, sender gaps, receiver stalls, both.
  localparam int unsigned IdlePct [4] = '{0, 51, 0, 23};
  localparam int unsigned StallPct[4] = '{0, 0, 51, 23};
  // Station IDs per phase; the third phase draws a random one instead.
  localparam logic [7:0]  PhaseId [4] = '{8'hFF, 8'h00, 8'h5A, 8'h01};

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        rx_valid  = 1'b0;
  logic [7:0]  rx_data   = 8'h00;
  logic        rx_ready;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [15:0] res_data;
  logic [1:0]  res_user;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'h00;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_asks  = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned id_writes  = 0;
  logic [7:0]  cur_id     = 8'd1;

  int unsigned bad_words;
  int unsigned waiting;
  int unsigned bytes_taken;
  int unsigned words_seen;
  int unsigned crc_passes;

  always #2ns clk_i = ~clk_i;

  addressed_frame_crc6_receiver_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (rx_valid),
    .s_axis_tready_o (rx_ready),
    .s_axis_tdata_i  (rx_data),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_data),
    .m_axis_tuser_o  (res_user),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  // The checker sits on all three channels and owns the prediction.
  afcrc_frame_checker u_frame_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .rx_valid_i    (rx_valid),
    .rx_ready_i    (rx_ready),
    .rx_data_i     (rx_data),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_i    (res_data),
    .res_user_i    (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .mismatches_o  (bad_words),
    .outstanding_o (waiting),
    .bytes_o       (bytes_taken),
    .words_o       (words_seen),
    .passes_o      (crc_passes)
  );

  // Result side. Ready is redrawn every cycle at the current stall rate, except while a
  // hold-off requested by the stimulus is counting down, when it stays low throughout.
  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen  = hold_asks;
      hold_count = HoldOffCycles;
    end
    if (hold_count != 0) begin
      hold_count--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any word moving on any channel restarts the count of quiet cycles.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((rx_valid && rx_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: no word moved for %0d cycles", QuietLimit);
    $display("FAILED: results differ");
    $finish;
  end

  // Offers one byte, possibly after a random gap, and returns at the edge that takes it.
  // Ready is sampled at the falling edge, where it already holds its value for the next
  // rising edge. Valid stays high afterward so back-to-back words need no gap.
  task automatic put_byte(input logic [7:0] b);
    logic took;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      rx_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    rx_valid <= 1'b1;
    rx_data  <= b;
    do begin
      @(negedge clk_i);
      took = rx_ready;
      @(posedge clk_i);
    end while (!took);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every predicted result word has come back.
  task automatic await_drained();
    rx_valid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
    @(posedge clk_i);
  endtask

  // The station ID only changes with the block idle. A stray byte that ends no frame may
  // still sit in the input register when the last word arrives, so SettleCycles pass first.
  task automatic write_station_id(input logic [7:0] id);
    logic took;
    await_drained();
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= id;
    do begin
      @(negedge clk_i);
      took = cfg_ready;
      @(posedge clk_i);
    end while (!took);
    cfg_valid <= 1'b0;
    cur_id = id;
    id_writes++;
  endtask

  // Sends one four-byte frame. A bad frame has one of its six check bits flipped; the
  // two unused top bits of the check byte are set as given.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] left,
                            input logic [7:0] right, input logic good,
                            input logic [1:0] top);
    logic [7:0] chk;
    chk = sealing_byte(id, left, right);
    if (!good) begin
      chk[$urandom_range(5)] ^= 1'b1;
    end
    chk[7:6] = top;
    put_byte(id);
    put_byte(left);
    put_byte(right);
    put_byte(chk);
  endtask

  // Motor commands lean toward zero and the two signed extremes.
  function automatic logic [7:0] rand_cmd();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'h7F;
      2:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    logic [7:0]  left;
    logic [7:0]  right;
    logic [7:0]  noise;
    logic        held_once;
    logic        paused_once;
    held_once   = 1'b0;
    paused_once = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with the station ID left at its reset value of one.
    // Bytes other than the ID are dropped while the block waits for a frame.
    put_byte(8'h00);
    put_byte(8'hFF);
    // Largest positive and most negative commands, in both orders.
    send_frame(cur_id, 8'h7F, 8'h80, 1'b1, 2'b00);
    send_frame(cur_id, 8'h80, 8'h7F, 1'b1, 2'b11);
    // Both commands zero raises the stop flag.
    send_frame(cur_id, 8'h00, 8'h00, 1'b1, 2'b01);
    // A failing check keeps the held zeros but still yields a word with crc_ok low.
    send_frame(cur_id, 8'h05, 8'hF9, 1'b0, 2'b10);
    // The ID value inside the frame body is plain data.
    send_frame(cur_id, cur_id, cur_id, 1'b1, 2'b00);
    send_frame(cur_id, 8'hFF, 8'h00, 1'b1, 2'b11);

    // Random part: mostly well-formed frames with random content, some noise bytes, and
    // some frames cut short, which take their missing bytes from whatever follows.
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IdlePct[p];
      stall_pct = StallPct[p];
      write_station_id((p == 2) ? 8'($urandom) : PhaseId[p]);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        // With no gaps on the sender, one long hold-off on the result side lets the
        // block fill up and push back on its input.
        if (p == 0 && !held_once && bytes_sent - phase_start >= 60) begin
          hold_asks++;
          held_once = 1'b1;
        end
        // Once, the sender pauses until every pending result word has come back.
        if (p == 2 && !paused_once && bytes_sent - phase_start >= 100) begin
          await_drained();
          paused_once = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 75) begin
          left  = rand_cmd();
          right = rand_cmd();
          if ($urandom_range(9) == 0) begin
            left  = 8'h00;
            right = 8'h00;
          end
          send_frame(cur_id, left, right, $urandom_range(3) != 0, 2'($urandom_range(3)));
        end else if (pick < 88) begin
          noise = 8'($urandom);
          if (noise == cur_id) begin
            noise = noise + 8'd1;
          end
          put_byte(noise);
        end else begin
          put_byte(cur_id);
          repeat ($urandom_range(1, 2)) put_byte(8'($urandom));
        end
      end
    end

    await_drained();
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("Run covered %0d received bytes and %0d result words, %0d of them with a good check,",
             bytes_taken, words_seen, crc_passes);
    $display("under %0d station ID writes and four pacing mixes plus a long result hold-off.",
             id_writes);
    if (waiting != 0) begin
      $display("%0d predicted result words never arrived", waiting);
    end
    if (bad_words == 0 && waiting == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/afcrc_pkg.sv
rtl/core/afcrc_frame.sv
rtl/core/afcrc_out_reg.sv
rtl/core/addressed_frame_crc6_receiver_unit.sv
rtl/core/afcrc_checker.sv
dv/afcrc_frame_checker.sv
dv/addressed_frame_crc6_receiver_unit_test.sv
